### rtl/mfat_pkg.sv
package mfat_pkg;

  // Slot count and field widths
  localparam int NUM_MOTORS = 8;
  localparam int SLOT_W     = 3;
  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int CUR_IN_W   = 16;
  localparam int CUR_W      = 14;
  localparam int HALL_W     = 8;
  localparam int TURN_W     = 24;
  localparam int TOTAL_W    = 37;
  localparam int COUNT_W    = 7;
  localparam int CALIB_W    = 6;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CALIB_W-1:0] CALIB_RESET = 6'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

  // Angle jump threshold (half of one mechanical turn in counts)
  localparam logic signed [ANGLE_W:0] HALF_TURN = 17'sd4096;
  localparam int FULL_TURN_SHIFT = 13;

  localparam logic signed [TURN_W-1:0] TURN_MAX = 24'sh7FFFFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 24'sh800000;
  localparam logic signed [TOTAL_W:0]  TOTAL_MAX = 38'sd68719476735;

  // x / 5 for 16-bit unsigned x: (x * 52429) >> 18
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int DIV5_SHIFT = 18;

  // Register map (byte addresses)
  typedef enum logic [ADDR_W-1:0] {
    REG_CALIB = 3'd0
  } reg_addr_t;

  // One decoded feedback frame
  typedef struct packed {
    logic [SLOT_W-1:0]          slot;
    logic [ANGLE_W-1:0]         angle;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [CUR_IN_W-1:0] current;
    logic [HALL_W-1:0]          hall;
  } frame_t;

  // Per-slot tracker state
  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic [ANGLE_W-1:0]        angle;
    logic [ANGLE_W-1:0]        offset;
    logic signed [TURN_W-1:0]  turns;
    logic signed [SPEED_W-1:0] speed;
    logic signed [CUR_W-1:0]   current;
    logic [HALL_W-1:0]         hall;
  } slot_state_t;

endpackage

### rtl/motor_feedback_angle_tracker_top.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------------
// frame in | input     | in_valid/in_stall  | motor_slot, angle_word, speed_word, current_word,
//          |           |                    | hall_byte
// result   | output    | out_valid/out_stall| slot_out .. total_angle_out
// config   | input     | APB (psel/penable) | calib_frames at byte address 0
//
// The result is registered: input register, then one pass of per-slot
// read-modify-write into the result register. One frame per cycle sustained while the
// result is not stalled; the slot state file is written in the same cycle it is read.
// Synchronous reset clears all slot state and sets calib_frames to 50.
// A stalled result holds; the input register still takes a frame while empty.
module motor_feedback_angle_tracker_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // frame input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mfat_pkg::SLOT_W-1:0]          motor_slot,
  input  logic [mfat_pkg::ANGLE_W-1:0]         angle_word,
  input  logic signed [mfat_pkg::SPEED_W-1:0]  speed_word,
  input  logic signed [mfat_pkg::CUR_IN_W-1:0] current_word,
  input  logic [mfat_pkg::HALL_W-1:0]          hall_byte,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mfat_pkg::SLOT_W-1:0]          slot_out,
  output logic                                 calibrating,
  output logic [mfat_pkg::ANGLE_W-1:0]         angle_out,
  output logic [mfat_pkg::ANGLE_W-1:0]         offset_out,
  output logic signed [mfat_pkg::SPEED_W-1:0]  speed_out,
  output logic signed [mfat_pkg::CUR_W-1:0]    current_out,
  output logic [mfat_pkg::HALL_W-1:0]          hall_out,
  output logic signed [mfat_pkg::TURN_W-1:0]   turns_out,
  output logic signed [mfat_pkg::TOTAL_W-1:0]  total_angle_out,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mfat_pkg::ADDR_W-1:0]          paddr,
  input  logic [mfat_pkg::DATA_W-1:0]          pwdata,
  output logic [mfat_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import mfat_pkg::*;

  logic [CALIB_W-1:0]       calib_frames;
  logic                     s1_valid;
  frame_t                   s1_frame;
  slot_state_t              slot_st [NUM_MOTORS];
  slot_state_t              st_cur;
  slot_state_t              st_next;
  logic                     upd_cal;
  logic signed [TOTAL_W-1:0] upd_total;
  logic                     out_ready;
  logic                     advance;
  logic                     in_range;
  logic                     cfg_write;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_CALIB) ? {{(DATA_W - CALIB_W){1'b0}}, calib_frames}
                                          : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_frames <= CALIB_RESET;
    end else if (cfg_write && (paddr == REG_CALIB)) begin
      calib_frames <= pwdata[CALIB_W-1:0];
    end
  end

  // Flow control
  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_frame <= '{slot: motor_slot, angle: angle_word, speed: speed_word,
                    current: current_word, hall: hall_byte};
    end
  end

  // Slot state read and update
  assign in_range = ({{(32 - SLOT_W){1'b0}}, s1_frame.slot} < 32'(NUM_MOTORS));
  assign st_cur   = slot_st[s1_frame.slot];

  mfat_update u_update (
    .cur          (st_cur),
    .frm          (s1_frame),
    .calib_frames (calib_frames),
    .nxt          (st_next),
    .cal          (upd_cal),
    .total        (upd_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOTORS; i++) slot_st[i] <= '0;
    end else if (advance && in_range) begin
      slot_st[s1_frame.slot] <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot_out <= s1_frame.slot;
      if (in_range) begin
        calibrating     <= upd_cal;
        angle_out       <= st_next.angle;
        offset_out      <= st_next.offset;
        speed_out       <= st_next.speed;
        current_out     <= st_next.current;
        hall_out        <= st_next.hall;
        turns_out       <= st_next.turns;
        total_angle_out <= upd_total;
      end else begin
        calibrating     <= 1'b0;
        angle_out       <= '0;
        offset_out      <= '0;
        speed_out       <= '0;
        current_out     <= '0;
        hall_out        <= '0;
        turns_out       <= '0;
        total_angle_out <= '0;
      end
    end
  end

  // Checks
  a_cal_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrating |-> angle_out == offset_out)
    else $error("calibration result with angle differing from offset");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && (turns_out != TURN_MAX) |->
      total_angle_out == ({turns_out[TOTAL_W-FULL_TURN_SHIFT-1:0], {FULL_TURN_SHIFT{1'b0}}}
                          + {{(TOTAL_W - ANGLE_W){1'b0}}, angle_out}))
    else $error("total angle does not match turns and angle");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_out >= -14'sd6553) && (current_out <= 14'sd6553))
    else $error("scaled current out of range");

  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_frame))
    else $error("pending frame lost while result stalled");

endmodule

### rtl/mfat_update.sv
module mfat_update (
  input  mfat_pkg::slot_state_t                cur,
  input  mfat_pkg::frame_t                     frm,
  input  logic [mfat_pkg::CALIB_W-1:0]         calib_frames,
  output mfat_pkg::slot_state_t                nxt,
  output logic                                 cal,
  output logic signed [mfat_pkg::TOTAL_W-1:0]  total
);
  import mfat_pkg::*;

  logic signed [ANGLE_W:0]   delta;
  logic                      cur_neg;
  logic [CUR_IN_W-1:0]       cur_mag;
  logic [31:0]               div_prod;
  logic [CUR_W-1:0]          quo;
  logic signed [CUR_W-1:0]   cur_scaled;
  logic signed [TURN_W-1:0]  turns_upd;
  logic signed [TOTAL_W:0]   total_raw;

  // Calibration window check against the count before this frame
  assign cal = (cur.count <= {1'b0, calib_frames});

  // Signed jump from the previous stored angle
  assign delta = $signed({1'b0, frm.angle}) - $signed({1'b0, cur.angle});

  // current / -5, truncated toward zero: divide magnitude, then fix sign
  assign cur_neg    = frm.current[CUR_IN_W-1];
  assign cur_mag    = cur_neg ? CUR_IN_W'(-frm.current) : CUR_IN_W'(frm.current);
  assign div_prod   = {16'd0, cur_mag} * {16'd0, DIV5_RECIP};
  assign quo        = div_prod[DIV5_SHIFT +: CUR_W];
  assign cur_scaled = cur_neg ? $signed(quo) : $signed(CUR_W'(-quo));

  // Saturating turn counter: big forward jump means a wrap downward
  always_comb begin
    turns_upd = cur.turns;
    if (delta > HALF_TURN) begin
      if (cur.turns != TURN_MIN) turns_upd = cur.turns - 24'sd1;
    end else if (delta < -HALF_TURN) begin
      if (cur.turns != TURN_MAX) turns_upd = cur.turns + 24'sd1;
    end
  end

  // Next slot state
  always_comb begin
    nxt       = cur;
    nxt.count = (cur.count == COUNT_MAX) ? cur.count : cur.count + 7'd1;
    nxt.angle = frm.angle;
    if (cal) begin
      nxt.offset = frm.angle;
    end else begin
      nxt.speed   = frm.speed;
      nxt.current = cur_scaled;
      nxt.hall    = frm.hall;
      nxt.turns   = turns_upd;
    end
  end

  // Total angle = turns * 8192 + angle, clipped at the positive limit
  assign total_raw = $signed({nxt.turns[TURN_W-1], nxt.turns, {FULL_TURN_SHIFT{1'b0}}})
                   + $signed({{(TOTAL_W + 1 - ANGLE_W){1'b0}}, nxt.angle});
  assign total = (total_raw > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : total_raw[TOTAL_W-1:0];

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfat_pkg::*;

  localparam int PIPE_LAT      = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HALF_TURN_CNT = 4096;
  localparam int FULL_TURN_CNT = 8192;
  localparam longint TOTAL_CAP = 64'sd68719476735;

  // One tracker result as seen on the output channel
  typedef struct packed {
    logic [SLOT_W-1:0]          slot;
    logic                       cal;
    logic [ANGLE_W-1:0]         angle;
    logic [ANGLE_W-1:0]         offset;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [CUR_W-1:0]    current;
    logic [HALL_W-1:0]          hall;
    logic signed [TURN_W-1:0]   turns;
    logic signed [TOTAL_W-1:0]  total;
  } fb_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [SLOT_W-1:0]          motor_slot = '0;
  logic [ANGLE_W-1:0]         angle_word = '0;
  logic signed [SPEED_W-1:0]  speed_word = '0;
  logic signed [CUR_IN_W-1:0] current_word = '0;
  logic [HALL_W-1:0]          hall_byte = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [SLOT_W-1:0]          slot_out;
  logic                       calibrating;
  logic [ANGLE_W-1:0]         angle_out;
  logic [ANGLE_W-1:0]         offset_out;
  logic signed [SPEED_W-1:0]  speed_out;
  logic signed [CUR_W-1:0]    current_out;
  logic [HALL_W-1:0]          hall_out;
  logic signed [TURN_W-1:0]   turns_out;
  logic signed [TOTAL_W-1:0]  total_angle_out;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // Tracker shadow: per-slot state and capture window
  slot_state_t        trk_state [NUM_MOTORS];
  logic [CALIB_W-1:0] calib_val;
  fb_result_t         pending_results [$];

  // Per-slot rotor trajectories for well-formed traffic
  int path_angle [NUM_MOTORS];
  int path_dir   [NUM_MOTORS];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int quiet_cycles = 0;
  int err_count    = 0;
  int frames_sent  = 0;
  int results_seen = 0;
  int calib_seen   = 0;
  int turn_steps   = 0;

  motor_feedback_angle_tracker_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .motor_slot      (motor_slot),
    .angle_word      (angle_word),
    .speed_word      (speed_word),
    .current_word    (current_word),
    .hall_byte       (hall_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slot_out        (slot_out),
    .calibrating     (calibrating),
    .angle_out       (angle_out),
    .offset_out      (offset_out),
    .speed_out       (speed_out),
    .current_out     (current_out),
    .hall_out        (hall_out),
    .turns_out       (turns_out),
    .total_angle_out (total_angle_out),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker update for one frame; returns the snapshot the block should report
  function automatic fb_result_t track_frame(frame_t f);
    slot_state_t s;
    fb_result_t  r;
    logic        cal;
    int          delta;
    int          cur_div;
    longint      total;
    r = '0;
    r.slot = f.slot;
    if (int'(f.slot) >= NUM_MOTORS) return r;
    s = trk_state[f.slot];
    cal = (s.count <= {1'b0, calib_val});
    if (s.count < COUNT_MAX) s.count = s.count + 1'b1;
    if (cal) begin
      s.angle  = f.angle;
      s.offset = f.angle;
    end else begin
      delta = int'($signed({1'b0, f.angle}) - $signed({1'b0, s.angle}));
      s.angle = f.angle;
      s.speed = f.speed;
      cur_div = int'(f.current);
      cur_div = -(cur_div / 5);
      s.current = cur_div[CUR_W-1:0];
      s.hall = f.hall;
      // jump forward past half a turn means the rotor wrapped backward
      if (delta > HALF_TURN_CNT) begin
        if (s.turns != TURN_MIN) s.turns = s.turns - 24'sd1;
        turn_steps++;
      end else if (delta < -HALF_TURN_CNT) begin
        if (s.turns != TURN_MAX) s.turns = s.turns + 24'sd1;
        turn_steps++;
      end
    end
    trk_state[f.slot] = s;
    total = longint'(s.turns) * FULL_TURN_CNT + longint'(s.angle);
    if (total > TOTAL_CAP) total = TOTAL_CAP;
    r.cal     = cal;
    r.angle   = s.angle;
    r.offset  = s.offset;
    r.speed   = s.speed;
    r.current = s.current;
    r.hall    = s.hall;
    r.turns   = s.turns;
    r.total   = total[TOTAL_W-1:0];
    return r;
  endfunction

  // Send one frame, with an optional idle burst first; predict on acceptance
  task automatic push_frame(input logic [SLOT_W-1:0] s, input logic [ANGLE_W-1:0] a,
                            input logic [SPEED_W-1:0] sp, input logic [CUR_IN_W-1:0] c,
                            input logic [HALL_W-1:0] h);
    frame_t f;
    f = {s, a, sp, c, h};
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    motor_slot   <= s;
    angle_word   <= a;
    speed_word   <= sp;
    current_word <= c;
    hall_byte    <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(track_frame(f));
    frames_sent++;
  endtask

  // Next frame of a slot's rotor trajectory, or a noise frame
  task automatic push_track(input int s, input int noise_pct);
    logic [31:0]        rnd_a;
    logic [31:0]        rnd_b;
    logic [ANGLE_W-1:0] a;
    int                 step;
    int                 pos;
    rnd_a = $urandom;
    rnd_b = $urandom;
    if ($urandom_range(0, 99) < noise_pct) begin
      a = rnd_b[31:16];
    end else begin
      if ($urandom_range(0, 15) == 0) path_dir[s] = -path_dir[s];
      step = ($urandom_range(0, 19) == 0) ? $urandom_range(4097, 8000)
                                          : $urandom_range(0, 3000);
      pos = (path_angle[s] + path_dir[s] * step) & (FULL_TURN_CNT - 1);
      a = pos[ANGLE_W-1:0];
    end
    path_angle[s] = int'(a[12:0]);
    push_frame(s[SLOT_W-1:0], a, rnd_a[15:0], rnd_a[31:16], rnd_b[7:0]);
  endtask

  // Hold the sender until every expected result is out and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic read_calib();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_CALIB;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(calib_val)) begin
      err_count++;
      if (err_count <= 10)
        $display("calib_frames readback: expected %0d, got %0d", calib_val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write only while the tracker is idle, then read back
  task automatic set_calib(input int v);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CALIB;
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    calib_val = v[CALIB_W-1:0];
    read_calib();
  endtask

  // Field extremes, turn thresholds, division rounding, capture re-entry
  task automatic test_field_extremes();
    set_calib(0);
    push_frame(3'd0, 16'd0,     16'h0000, 16'h0000, 8'h00);
    push_frame(3'd0, 16'd8191,  16'h7FFF, 16'h8000, 8'hFF);
    push_frame(3'd0, 16'd0,     16'h8000, 16'h7FFF, 8'h00);
    push_frame(3'd0, 16'd4096,  16'h0001, 16'hFFFF, 8'h01);
    push_frame(3'd0, 16'd0,     16'hFFFF, 16'h0004, 8'h80);
    push_frame(3'd0, 16'd4097,  16'h0100, 16'hFFFB, 8'h10);
    push_frame(3'd0, 16'd0,     16'hFF00, 16'h0005, 8'h20);
    // angle outside one turn is taken as is
    push_frame(3'd0, 16'd65535, 16'h1234, 16'h0006, 8'h40);
    push_frame(3'd0, 16'd1000,  16'hEDCB, 16'hFFF9, 8'h7F);
    push_frame(3'd7, 16'hAAAA,  16'h5555, 16'h5555, 8'hAA);
    push_frame(3'd7, 16'h5555,  16'hAAAA, 16'hAAAA, 8'h55);
    // widening the window puts slots with low counts back into capture
    set_calib(63);
    push_frame(3'd0, 16'd8000,  16'h0000, 16'h0000, 8'h00);
    push_frame(3'd3, 16'd123,   16'h0000, 16'h0000, 8'h00);
    push_frame(3'd7, 16'd7000,  16'h0000, 16'h0000, 8'h00);
  endtask

  // Move the capture window while slots 4..6 count through it
  task automatic test_calib_walk();
    int steps [6] = '{10, 5, 40, 20, 63, 50};
    tx_idle_pct  = 25;
    rx_stall_pct = 10;
    foreach (steps[k]) begin
      set_calib(steps[k]);
      repeat (20) push_track($urandom_range(4, 6), 10);
    end
  endtask

  // Smooth rotation on all slots, wrapping in both directions
  task automatic test_spin();
    set_calib($urandom_range(1, 62));
    foreach (path_dir[i]) path_dir[i] = $urandom_range(0, 1) ? 1 : -1;
    for (int blk = 0; blk < 4; blk++) begin
      tx_idle_pct  = (blk % 2) ? 0 : 30;
      rx_stall_pct = (blk < 2) ? 15 : 0;
      repeat (150) push_track($urandom_range(0, NUM_MOTORS - 1), 5);
    end
  endtask

  // Mixed trajectories and noise; one full pause mid-run, no idling at the end
  task automatic test_random_mix();
    set_calib($urandom_range(0, 63));
    for (int blk = 0; blk < 11; blk++) begin
      case ($urandom_range(0, 2))
        0: tx_idle_pct = 0;
        1: tx_idle_pct = 15;
        default: tx_idle_pct = 50;
      endcase
      rx_stall_pct = $urandom_range(0, 1) ? 20 : 0;
      if (blk >= 9) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      if (blk == 5) drain_results();
      repeat (100) push_track($urandom_range(0, NUM_MOTORS - 1), 20);
    end
  endtask

  // Result receiver: random stall bursts
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= 1'b1;
    end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct / 3) begin
      rx_hold   <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    fb_result_t want;
    fb_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {slot_out, calibrating, angle_out, offset_out, speed_out, current_out,
             hall_out, turns_out, total_angle_out};
      results_seen++;
      if (got.cal) calib_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result for slot %0d", got.slot);
      end else begin
        want = pending_results.pop_front();
        if (want.slot !== got.slot || want.cal !== got.cal || want.angle !== got.angle ||
            want.offset !== got.offset || want.speed !== got.speed ||
            want.current !== got.current || want.hall !== got.hall ||
            want.turns !== got.turns || want.total !== got.total) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  exp slot %0d cal %0d ang %0d off %0d spd %0d cur %0d hall %0d turns %0d total %0d",
                     want.slot, want.cal, want.angle, want.offset, want.speed,
                     want.current, want.hall, want.turns, want.total);
            $display("  got slot %0d cal %0d ang %0d off %0d spd %0d cur %0d hall %0d turns %0d total %0d",
                     got.slot, got.cal, got.angle, got.offset, got.speed,
                     got.current, got.hall, got.turns, got.total);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    calib_val = CALIB_RESET;
    foreach (trk_state[i]) trk_state[i] = '0;
    foreach (path_angle[i]) begin
      path_angle[i] = 0;
      path_dir[i]   = 1;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    read_calib();
    test_field_extremes();
    test_calib_walk();
    test_spin();
    test_random_mix();
    drain_results();
    if (pending_results.size() != 0) err_count++;
    $display("%0d feedback frames, %0d results checked, %0d in offset capture, %0d turn steps.",
             frames_sent, results_seen, calib_seen, turn_steps);
    $display("Capture window moved across 0..63 from its reset value; idling on both sides.");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
